// ----- rtl/cmws_pkg.sv -----
// ----------------------------------------------------------------------------
// cmws_pkg
// Types and codes shared by the multi-block card write sequencer modules.
// ----------------------------------------------------------------------------
package cmws_pkg;

  // action codes on the input side
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_POLL    = 2'd1;
  localparam logic [1:0] ACT_REQUEST = 2'd2;
  localparam logic [1:0] ACT_SUBMIT  = 2'd3;

  // access kinds
  localparam logic [1:0] ACC_NONE        = 2'd0;
  localparam logic [1:0] ACC_REG_WRITE   = 2'd1;
  localparam logic [1:0] ACC_SEND_BUFFER = 2'd2;

  // host register selects
  localparam logic [2:0] SEL_SIZE_COUNT   = 3'd0;
  localparam logic [2:0] SEL_STATUS_CLEAR = 3'd1;
  localparam logic [2:0] SEL_ARGUMENT     = 3'd2;
  localparam logic [2:0] SEL_COMMAND      = 3'd3;
  localparam logic [2:0] SEL_DATA_PORT    = 3'd4;

  // job status
  localparam logic [1:0] JOB_IDLE  = 2'd0;
  localparam logic [1:0] JOB_BUSY  = 2'd1;
  localparam logic [1:0] JOB_DONE  = 2'd2;
  localparam logic [1:0] JOB_ERROR = 2'd3;

  // buffer conditions
  localparam logic [1:0] BUF_EMPTY   = 2'd0;
  localparam logic [1:0] BUF_FILLING = 2'd1;
  localparam logic [1:0] BUF_READY   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_BLOCK_BYTES         = 3'd0;
  localparam logic [2:0] REG_ERROR_BITS          = 3'd1;
  localparam logic [2:0] REG_COMMAND_DONE_BIT    = 3'd2;
  localparam logic [2:0] REG_TRANSFER_DONE_BIT   = 3'd3;
  localparam logic [2:0] REG_WRITE_READY_BIT     = 3'd4;
  localparam logic [2:0] REG_MULTI_WRITE_COMMAND = 3'd5;

  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam int          COUNT_SHIFT = 16;

  localparam int RES_MAX = 4;
  localparam int CNT_W   = $clog2(RES_MAX + 1);
  localparam int IDX_W   = $clog2(RES_MAX);

  typedef enum logic [2:0] {
    ST_SEND      = 3'd0,
    ST_POLL_CMD  = 3'd1,
    ST_FIND      = 3'd2,
    ST_POLL_BUF  = 3'd3,
    ST_WRITE     = 3'd4,
    ST_ADVANCE   = 3'd5,
    ST_POLL_XFER = 3'd6
  } step_t;

  typedef struct packed {
    logic [11:0] block_bytes;
    logic [31:0] error_bits;
    logic [31:0] command_done_bit;
    logic [31:0] transfer_done_bit;
    logic [31:0] write_ready_bit;
    logic [31:0] multi_write_command;
  } cfg_t;

  typedef struct packed {
    step_t           step;
    logic [1:0]      job;
    logic [31:0]     addr;
    logic [15:0]     total;
    logic [16:0]     done;
    logic            active;
    logic [1:0][1:0] cond;
  } job_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  sel;
    logic [31:0] value;
    logic        buf_idx;
    logic        grant;
  } result_t;

  function automatic result_t mk_res(logic [1:0] kind, logic [2:0] sel, logic [31:0] value,
                                     logic buf_idx, logic grant);
    result_t r;
    r.kind    = kind;
    r.sel     = sel;
    r.value   = value;
    r.buf_idx = buf_idx;
    r.grant   = grant;
    return r;
  endfunction

endpackage

// ----- rtl/cmws_pass.sv -----
// ----------------------------------------------------------------------------
// cmws_pass
// One scheduling pass: next job state and the group of results for one item.
// ----------------------------------------------------------------------------
module cmws_pass (
  input  logic [1:0]                                action,
  input  logic [31:0]                               start_block_address,
  input  logic [15:0]                               block_count,
  input  logic [31:0]                               sampled_status,
  input  cmws_pkg::cfg_t                            cfg,
  input  cmws_pkg::job_state_t                      cur,
  output cmws_pkg::job_state_t                      nxt,
  output cmws_pkg::result_t [cmws_pkg::RES_MAX-1:0] res,
  output logic [cmws_pkg::CNT_W-1:0]                count
);
  import cmws_pkg::*;

  logic        do_find;
  logic        do_pollbuf;
  logic        err;
  logic [16:0] done_inc;

  always_comb begin
    nxt        = cur;
    res        = '0;
    count      = '0;
    do_find    = 1'b0;
    do_pollbuf = 1'b0;
    done_inc   = cur.done + 17'd1;
    err        = |(sampled_status & cfg.error_bits);

    unique case (action)
      ACT_START: begin
        nxt.job    = JOB_BUSY;
        nxt.addr   = start_block_address;
        nxt.total  = block_count;
        nxt.done   = '0;
        nxt.active = 1'b0;
        nxt.cond   = {BUF_EMPTY, BUF_EMPTY};
        nxt.step   = ST_SEND;
      end
      ACT_POLL: begin
        if (cur.job == JOB_BUSY) begin
          unique case (cur.step)
            ST_SEND: begin
              res[0] = mk_res(ACC_REG_WRITE, SEL_SIZE_COUNT,
                              32'(cfg.block_bytes) | (32'(cur.total) << COUNT_SHIFT),
                              1'b0, 1'b0);
              res[1] = mk_res(ACC_REG_WRITE, SEL_STATUS_CLEAR, ALL_ONES, 1'b0, 1'b0);
              res[2] = mk_res(ACC_REG_WRITE, SEL_ARGUMENT, cur.addr, 1'b0, 1'b0);
              res[3] = mk_res(ACC_REG_WRITE, SEL_COMMAND, cfg.multi_write_command,
                              1'b0, 1'b0);
              count    = CNT_W'(4);
              nxt.step = ST_POLL_CMD;
            end
            ST_POLL_CMD: begin
              if (err) begin
                nxt.job = JOB_ERROR;
              end else if (|(sampled_status & cfg.command_done_bit)) begin
                res[0]   = mk_res(ACC_REG_WRITE, SEL_STATUS_CLEAR, cfg.command_done_bit,
                                  1'b0, 1'b0);
                count    = CNT_W'(1);
                nxt.step = ST_FIND;
              end
            end
            ST_FIND: begin
              do_find = 1'b1;
            end
            ST_POLL_BUF: begin
              do_pollbuf = 1'b1;
            end
            ST_WRITE: begin
              res[0]   = mk_res(ACC_SEND_BUFFER, SEL_DATA_PORT, '0, cur.active, 1'b0);
              count    = CNT_W'(1);
              nxt.step = ST_ADVANCE;
            end
            ST_ADVANCE: begin
              nxt.cond[cur.active] = BUF_EMPTY;
              nxt.done             = done_inc;
              if (done_inc >= {1'b0, cur.total}) begin
                nxt.step = ST_POLL_XFER;
              end else begin
                nxt.step = ST_FIND;
                do_find  = 1'b1;
              end
            end
            ST_POLL_XFER: begin
              if (err) begin
                nxt.job = JOB_ERROR;
              end else if (|(sampled_status & cfg.transfer_done_bit)) begin
                res[0]  = mk_res(ACC_REG_WRITE, SEL_STATUS_CLEAR, cfg.transfer_done_bit,
                                 1'b0, 1'b0);
                count   = CNT_W'(1);
                nxt.job = JOB_DONE;
              end
            end
            default: begin
            end
          endcase

          // look for a filled buffer, lowest index first
          if (do_find) begin
            if (nxt.cond[0] == BUF_READY) begin
              nxt.active = 1'b0;
              nxt.step   = ST_POLL_BUF;
              do_pollbuf = 1'b1;
            end else if (nxt.cond[1] == BUF_READY) begin
              nxt.active = 1'b1;
              nxt.step   = ST_POLL_BUF;
              do_pollbuf = 1'b1;
            end
          end

          // write ready: clear it and send the block in the same pass
          if (do_pollbuf) begin
            if (err) begin
              nxt.cond[nxt.active] = BUF_EMPTY;
              nxt.job              = JOB_ERROR;
            end else if (|(sampled_status & cfg.write_ready_bit)) begin
              res[0]   = mk_res(ACC_REG_WRITE, SEL_STATUS_CLEAR, cfg.write_ready_bit,
                                1'b0, 1'b0);
              res[1]   = mk_res(ACC_SEND_BUFFER, SEL_DATA_PORT, '0, nxt.active, 1'b0);
              count    = CNT_W'(2);
              nxt.step = ST_ADVANCE;
            end
          end
        end
      end
      ACT_REQUEST: begin
        if (cur.cond[0] == BUF_EMPTY) begin
          nxt.cond[0] = BUF_FILLING;
          res[0]      = mk_res(ACC_NONE, SEL_SIZE_COUNT, '0, 1'b0, 1'b1);
        end else if (cur.cond[1] == BUF_EMPTY) begin
          nxt.cond[1] = BUF_FILLING;
          res[0]      = mk_res(ACC_NONE, SEL_SIZE_COUNT, '0, 1'b1, 1'b1);
        end
        count = CNT_W'(1);
      end
      ACT_SUBMIT: begin
        if (cur.cond[0] == BUF_FILLING) begin
          nxt.cond[0] = BUF_READY;
        end else if (cur.cond[1] == BUF_FILLING) begin
          nxt.cond[1] = BUF_READY;
          res[0]      = mk_res(ACC_NONE, SEL_SIZE_COUNT, '0, 1'b1, 1'b0);
        end
        count = CNT_W'(1);
      end
    endcase

    // an item with no access still answers once
    if (count == '0) begin
      count = CNT_W'(1);
    end
  end

endmodule

// ----- rtl/cmws_result_buf.sv -----
// ----------------------------------------------------------------------------
// cmws_result_buf
// Holds an item's result group; one transfer a cycle while m_tready is high.
// ----------------------------------------------------------------------------
module cmws_result_buf (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  cmws_pkg::result_t [cmws_pkg::RES_MAX-1:0] grp,
  input  logic [cmws_pkg::CNT_W-1:0]                grp_count,
  input  logic [1:0]                                grp_status,
  output logic                                      free,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // register_select[2:0], write_value[34:3], buffer_index[35],
  // buffer_granted[36], transfer_status[38:37], zero pad[39]
  output logic [39:0]                               m_tdata,
  // access_kind[1:0]
  output logic [1:0]                                m_tuser,
  output logic                                      m_tlast
);
  import cmws_pkg::*;

  result_t [RES_MAX-1:0] grp_q;
  logic [CNT_W-1:0]      count_q;
  logic [1:0]            status_q;
  logic [IDX_W-1:0]      idx;
  logic                  valid;
  logic                  is_last;
  result_t               head;

  assign head     = grp_q[idx];
  assign is_last  = (CNT_W'(idx) == count_q - CNT_W'(1));
  assign free     = !valid || (m_tready && is_last);
  assign m_tvalid = valid;
  assign m_tlast  = is_last;
  assign m_tuser  = head.kind;
  assign m_tdata  = {1'b0, status_q, head.grant, head.buf_idx, head.value, head.sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && m_tready) begin
      if (is_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_q    <= grp;
      count_q  <= grp_count;
      status_q <= grp_status;
    end
  end

endmodule

// ----- rtl/card_multiblock_write_sequencer.sv -----
// ----------------------------------------------------------------------------
// card_multiblock_write_sequencer
// Multi-block card write sequencer for a host controller with two ping-pong
// data buffers: start, status poll, buffer request and buffer submit items.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tuser action, s_tdata address/count/status
//   m_*      out  m_tvalid/m_tready  m_tuser access kind, m_tdata write, m_tlast
//   cfg_*    in   cfg_we             cfg_index, cfg_data (write only)
//
// An item waits in the input register until its pass result loads the result
// buffer, which gives one transfer per cycle while m_tready is high. An item
// gives 1 to 4 transfers, its result count (four on the command send poll).
// The input register takes a new item while the previous results drain.
// Reset (rst, synchronous) clears job state and loads the register defaults.
// ----------------------------------------------------------------------------
module card_multiblock_write_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_block_address[31:0], block_count[47:32], sampled_status[79:48]
  input  logic [79:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // register_select[2:0], write_value[34:3], buffer_index[35],
  // buffer_granted[36], transfer_status[38:37], zero pad[39]
  output logic [39:0] m_tdata,
  // access_kind[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cmws_pkg::*;

  cfg_t                  cfg;
  job_state_t            cur;
  job_state_t            cur_next;
  result_t [RES_MAX-1:0] grp;
  logic [CNT_W-1:0]      grp_count;
  logic                  rb_free;
  logic                  take;

  logic        in_valid;
  logic [1:0]  in_action;
  logic [31:0] in_addr;
  logic [15:0] in_count;
  logic [31:0] in_status;

  assign take     = in_valid && rb_free;
  assign s_tready = !in_valid || rb_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_addr   <= s_tdata[31:0];
      in_count  <= s_tdata[47:32];
      in_status <= s_tdata[79:48];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_bytes         <= 12'd512;
      cfg.error_bits          <= 32'hFFFF_8000;
      cfg.command_done_bit    <= 32'd1;
      cfg.transfer_done_bit   <= 32'd2;
      cfg.write_ready_bit     <= 32'd16;
      cfg.multi_write_command <= 32'd423231522;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_BYTES:         cfg.block_bytes         <= cfg_data[11:0];
        REG_ERROR_BITS:          cfg.error_bits          <= cfg_data;
        REG_COMMAND_DONE_BIT:    cfg.command_done_bit    <= cfg_data;
        REG_TRANSFER_DONE_BIT:   cfg.transfer_done_bit   <= cfg_data;
        REG_WRITE_READY_BIT:     cfg.write_ready_bit     <= cfg_data;
        REG_MULTI_WRITE_COMMAND: cfg.multi_write_command <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.step   <= ST_SEND;
      cur.job    <= JOB_IDLE;
      cur.addr   <= '0;
      cur.total  <= '0;
      cur.done   <= '0;
      cur.active <= 1'b0;
      cur.cond   <= {BUF_EMPTY, BUF_EMPTY};
    end else if (take) begin
      cur <= cur_next;
    end
  end

  cmws_pass u_pass (
    .action              (in_action),
    .start_block_address (in_addr),
    .block_count         (in_count),
    .sampled_status      (in_status),
    .cfg                 (cfg),
    .cur                 (cur),
    .nxt                 (cur_next),
    .res                 (grp),
    .count               (grp_count)
  );

  cmws_result_buf u_result_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .grp        (grp),
    .grp_count  (grp_count),
    .grp_status (cur_next.job),
    .free       (rb_free),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // a running job only ends in done or error, or restarts
  a_busy_not_idle: assert property (@(posedge clk) disable iff (rst)
    cur.job == JOB_BUSY |=> cur.job != JOB_IDLE)
    else $error("busy job fell back to idle");

  // the block counter never runs past the job length (a zero count sends one)
  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    cur.done <= {1'b0, cur.total} || cur.done == 17'd1)
    else $error("block counter past job length");

  // a block is only sent while the job is still running
  a_send_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ACC_SEND_BUFFER |-> m_tdata[38:37] == JOB_BUSY)
    else $error("buffer send outside a running job");

endmodule

// ----- dv/card_multiblock_write_sequencer_checker.sv -----
// ----------------------------------------------------------------------------
// card_multiblock_write_sequencer_checker
// Watches the item, result and register-write channels of the card write
// sequencer, predicts the host accesses that every accepted item causes and
// compares each result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module card_multiblock_write_sequencer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // start_block_address[31:0], block_count[47:32], sampled_status[79:48]
  input  logic [79:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // register_select[2:0], write_value[34:3], buffer_index[35],
  // buffer_granted[36], transfer_status[38:37], zero pad[39]
  input  logic [39:0] m_tdata,
  // access_kind[1:0]
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cmws_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  sel;
    logic [31:0] value;
    logic        buf_idx;
    logic        grant;
    logic [1:0]  status;
    logic        last;
  } host_access_t;

  // register copies
  logic [11:0] blk_bytes;
  logic [31:0] err_mask, cmd_done_mask, xfer_done_mask, wr_ready_mask, cmd_word;

  // job state
  step_t       step;
  logic [1:0]  job;
  logic [31:0] addr;
  logic [15:0] total;
  logic [16:0] done_cnt;
  logic        active;
  logic [1:0]  cond [2];

  host_access_t host_accesses_due[$];
  host_access_t pass_buf[RES_MAX];
  int           pass_n;

  function automatic void add_access(input logic [1:0] kind, input logic [2:0] sel,
                                     input logic [31:0] value, input logic buf_idx,
                                     input logic grant);
    if (pass_n < RES_MAX) begin
      pass_buf[pass_n] = '{kind, sel, value, buf_idx, grant, 2'b00, 1'b0};
      pass_n++;
    end
  endfunction

  // one scheduling pass of a busy job against the sampled status
  task automatic run_poll(input logic [31:0] st);
    bit go;
    go = 1'b1;
    if (job != JOB_BUSY) return;
    while (go) begin
      go = 1'b0;
      case (step)
        ST_SEND: begin
          add_access(ACC_REG_WRITE, SEL_SIZE_COUNT, {total, 4'd0, blk_bytes}, 1'b0, 1'b0);
          add_access(ACC_REG_WRITE, SEL_STATUS_CLEAR, ALL_ONES, 1'b0, 1'b0);
          add_access(ACC_REG_WRITE, SEL_ARGUMENT, addr, 1'b0, 1'b0);
          add_access(ACC_REG_WRITE, SEL_COMMAND, cmd_word, 1'b0, 1'b0);
          step = ST_POLL_CMD;
        end
        ST_POLL_CMD: begin
          if (|(st & err_mask)) begin
            job = JOB_ERROR;
          end else if (|(st & cmd_done_mask)) begin
            add_access(ACC_REG_WRITE, SEL_STATUS_CLEAR, cmd_done_mask, 1'b0, 1'b0);
            step = ST_FIND;
          end
        end
        ST_ADVANCE: begin
          cond[active] = BUF_EMPTY;
          done_cnt = done_cnt + 17'd1;
          if (done_cnt >= {1'b0, total}) begin
            step = ST_POLL_XFER;
          end else begin
            step = ST_FIND;
            go = 1'b1;
          end
        end
        ST_FIND: begin
          if (cond[0] == BUF_READY) begin
            active = 1'b0;
            step = ST_POLL_BUF;
            go = 1'b1;
          end else if (cond[1] == BUF_READY) begin
            active = 1'b1;
            step = ST_POLL_BUF;
            go = 1'b1;
          end
        end
        ST_POLL_BUF: begin
          if (|(st & err_mask)) begin
            cond[active] = BUF_EMPTY;
            job = JOB_ERROR;
          end else if (|(st & wr_ready_mask)) begin
            add_access(ACC_REG_WRITE, SEL_STATUS_CLEAR, wr_ready_mask, 1'b0, 1'b0);
            step = ST_WRITE;
            go = 1'b1;
          end
        end
        ST_WRITE: begin
          add_access(ACC_SEND_BUFFER, SEL_DATA_PORT, 32'd0, active, 1'b0);
          step = ST_ADVANCE;
        end
        ST_POLL_XFER: begin
          if (|(st & err_mask)) begin
            job = JOB_ERROR;
          end else if (|(st & xfer_done_mask)) begin
            add_access(ACC_REG_WRITE, SEL_STATUS_CLEAR, xfer_done_mask, 1'b0, 1'b0);
            job = JOB_DONE;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic predict_host_accesses(input logic [1:0] act, input logic [79:0] payload);
    pass_n = 0;
    case (act)
      ACT_START: begin
        job      = JOB_BUSY;
        addr     = payload[31:0];
        total    = payload[47:32];
        done_cnt = '0;
        active   = 1'b0;
        cond[0]  = BUF_EMPTY;
        cond[1]  = BUF_EMPTY;
        step     = ST_SEND;
      end
      ACT_POLL: run_poll(payload[79:48]);
      ACT_REQUEST: begin
        if (cond[0] == BUF_EMPTY) begin
          cond[0] = BUF_FILLING;
          add_access(ACC_NONE, SEL_SIZE_COUNT, 32'd0, 1'b0, 1'b1);
        end else if (cond[1] == BUF_EMPTY) begin
          cond[1] = BUF_FILLING;
          add_access(ACC_NONE, SEL_SIZE_COUNT, 32'd0, 1'b1, 1'b1);
        end
      end
      default: begin
        if (cond[0] == BUF_FILLING) begin
          cond[0] = BUF_READY;
          add_access(ACC_NONE, SEL_SIZE_COUNT, 32'd0, 1'b0, 1'b0);
        end else if (cond[1] == BUF_FILLING) begin
          cond[1] = BUF_READY;
          add_access(ACC_NONE, SEL_SIZE_COUNT, 32'd0, 1'b1, 1'b0);
        end
      end
    endcase
    // every item answers with at least one transfer
    if (pass_n == 0) add_access(ACC_NONE, SEL_SIZE_COUNT, 32'd0, 1'b0, 1'b0);
    for (int k = 0; k < pass_n; k++) begin
      pass_buf[k].status = job;
      pass_buf[k].last   = (k == pass_n - 1);
      host_accesses_due.push_back(pass_buf[k]);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    host_access_t seen, due;
    if (rst) begin
      blk_bytes      = 12'd512;
      err_mask       = 32'hFFFF_8000;
      cmd_done_mask  = 32'd1;
      xfer_done_mask = 32'd2;
      wr_ready_mask  = 32'd16;
      cmd_word       = 32'd423231522;
      step           = ST_SEND;
      job            = JOB_IDLE;
      addr           = '0;
      total          = '0;
      done_cnt       = '0;
      active         = 1'b0;
      cond[0]        = BUF_EMPTY;
      cond[1]        = BUF_EMPTY;
      host_accesses_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen = '{m_tuser, m_tdata[2:0], m_tdata[34:3], m_tdata[35], m_tdata[36],
                 m_tdata[38:37], m_tlast};
        if (host_accesses_due.size() == 0) begin
          $display("%0t: expected no result, got kind %0h sel %0h value %0h last %0b",
                   $time, seen.kind, seen.sel, seen.value, seen.last);
          mismatches++;
        end else begin
          due = host_accesses_due.pop_front();
          check_field("access_kind", 32'(due.kind), 32'(seen.kind));
          check_field("register_select", 32'(due.sel), 32'(seen.sel));
          check_field("write_value", due.value, seen.value);
          check_field("buffer_index", 32'(due.buf_idx), 32'(seen.buf_idx));
          check_field("buffer_granted", 32'(due.grant), 32'(seen.grant));
          check_field("transfer_status", 32'(due.status), 32'(seen.status));
          check_field("last", 32'(due.last), 32'(seen.last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_BYTES:         blk_bytes      = cfg_data[11:0];
          REG_ERROR_BITS:          err_mask       = cfg_data;
          REG_COMMAND_DONE_BIT:    cmd_done_mask  = cfg_data;
          REG_TRANSFER_DONE_BIT:   xfer_done_mask = cfg_data;
          REG_WRITE_READY_BIT:     wr_ready_mask  = cfg_data;
          REG_MULTI_WRITE_COMMAND: cmd_word       = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_host_accesses(s_tuser, s_tdata);
    end
    outstanding = host_accesses_due.size();
  end

endmodule

// ----- dv/card_multiblock_write_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// card_multiblock_write_sequencer_tb
// Drives start, poll, buffer request and buffer submit items into the card
// write sequencer: a directed opening, then randomized write jobs with noise
// and injected errors across several register settings, with random idling
// on both channels and one long output hold-off. The checker judges results.
// ----------------------------------------------------------------------------
module card_multiblock_write_sequencer_tb;
  import cmws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 160;
  localparam int PHASE_ITEMS = 52;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int send_run   = 0;
  int recv_run   = 0;
  bit hold_out   = 1'b0;

  // status bits as last written, used to shape poll statuses
  logic [31:0] err_shadow  = 32'hFFFF_8000;
  logic [31:0] cmd_shadow  = 32'd1;
  logic [31:0] xfer_shadow = 32'd2;
  logic [31:0] wr_shadow   = 32'd16;

  card_multiblock_write_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  card_multiblock_write_sequencer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // random idle cycles, with occasional stretches of back-to-back traffic
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run = $urandom_range(10, 30);
    return $urandom_range(0, 7);
  endfunction

  // random status with no error bits, plus the wanted bits
  function automatic logic [31:0] status_with(input logic [31:0] want);
    return ($urandom() & ~err_shadow) | want;
  endfunction

  // random status that carries at least one error bit when any is enabled
  function automatic logic [31:0] fault_status();
    return $urandom() | (err_shadow & (~err_shadow + 32'd1));
  endfunction

  task automatic put(input logic [1:0] act, input logic [31:0] addr,
                     input logic [15:0] cnt, input logic [31:0] st);
    int gap;
    gap = draw_gap(send_run);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = {st, cnt, addr};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
    items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ERROR_BITS:        err_shadow  = data;
      REG_COMMAND_DONE_BIT:  cmd_shadow  = data;
      REG_TRANSFER_DONE_BIT: xfer_shadow = data;
      REG_WRITE_READY_BIT:   wr_shadow   = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] bytes, input logic [31:0] errs,
                            input logic [31:0] cmd_done, input logic [31:0] xfer_done,
                            input logic [31:0] wr_ready, input logic [31:0] cmd);
    // block is idle once every result is back
    wait (outstanding == 0);
    repeat (4) @(negedge clk);
    write_reg(REG_BLOCK_BYTES, bytes);
    write_reg(REG_ERROR_BITS, errs);
    write_reg(REG_COMMAND_DONE_BIT, cmd_done);
    write_reg(REG_TRANSFER_DONE_BIT, xfer_done);
    write_reg(REG_WRITE_READY_BIT, wr_ready);
    write_reg(REG_MULTI_WRITE_COMMAND, cmd);
  endtask

  // stray items or an error poll; broke marks an error poll or a stray start
  task automatic inject_noise(output bit broke);
    int          pick;
    logic [1:0]  act;
    pick  = $urandom_range(0, 19);
    broke = 1'b0;
    if (pick == 0) begin
      put(ACT_POLL, $urandom(), 16'($urandom()), fault_status());
      broke = 1'b1;
    end else if (pick <= 2) begin
      act = 2'($urandom());
      put(act, $urandom(), 16'($urandom()), $urandom());
      broke = (act == ACT_START);
    end
  endtask

  task automatic run_write_job();
    logic [15:0] cnt;
    int          blocks;
    bit          broke;
    cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
    blocks = (cnt == 0) ? 1 : (cnt > 4) ? $urandom_range(1, 4) : int'(cnt);
    put(ACT_START, $urandom(), cnt, $urandom());
    put(ACT_POLL, $urandom(), 16'($urandom()), $urandom());
    if ($urandom_range(0, 3) == 0) put(ACT_POLL, $urandom(), 16'($urandom()),
                                       status_with(32'd0) & ~cmd_shadow);
    inject_noise(broke);
    if (broke) return;
    put(ACT_POLL, $urandom(), 16'($urandom()), status_with(cmd_shadow));
    for (int b = 0; b < blocks; b++) begin
      put(ACT_REQUEST, $urandom(), 16'($urandom()), $urandom());
      if ($urandom_range(0, 2) == 0) put(ACT_REQUEST, $urandom(), 16'($urandom()), $urandom());
      put(ACT_SUBMIT, $urandom(), 16'($urandom()), $urandom());
      if ($urandom_range(0, 3) == 0) put(ACT_SUBMIT, $urandom(), 16'($urandom()), $urandom());
      if ($urandom_range(0, 3) == 0) put(ACT_POLL, $urandom(), 16'($urandom()),
                                         status_with(32'd0) & ~wr_shadow);
      inject_noise(broke);
      if (broke) return;
      put(ACT_POLL, $urandom(), 16'($urandom()), status_with(wr_shadow));
      // advance pass; with a second buffer ready it may go on sending
      put(ACT_POLL, $urandom(), 16'($urandom()),
          $urandom_range(0, 1) ? status_with(wr_shadow) : status_with(32'd0));
    end
    inject_noise(broke);
    if (broke) return;
    put(ACT_POLL, $urandom(), 16'($urandom()), status_with(xfer_shadow));
  endtask

  // output side: random stalls, and one long hold-off when asked
  initial begin
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_out) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end
      gap = draw_gap(recv_run);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int target;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // buffer events and polls with no job running
    put(ACT_POLL, 32'd0, 16'd0, ALL_ONES);
    put(ACT_REQUEST, 32'd0, 16'd0, 32'd0);
    put(ACT_REQUEST, 32'd0, 16'd0, 32'd0);
    put(ACT_REQUEST, 32'd0, 16'd0, 32'd0);
    put(ACT_SUBMIT, 32'd0, 16'd0, 32'd0);
    put(ACT_SUBMIT, 32'd0, 16'd0, 32'd0);
    put(ACT_SUBMIT, 32'd0, 16'd0, 32'd0);
    // zero count still sends one block
    put(ACT_START, ALL_ONES, 16'd0, 32'd0);
    put(ACT_POLL, 32'd0, 16'd0, 32'd0);
    put(ACT_POLL, 32'd0, 16'd0, 32'd1);
    put(ACT_POLL, 32'd0, 16'd0, 32'd16);
    put(ACT_REQUEST, 32'd0, 16'd0, 32'd0);
    put(ACT_SUBMIT, 32'd0, 16'd0, 32'd0);
    put(ACT_POLL, 32'd0, 16'd0, 32'd16);
    put(ACT_POLL, 32'd0, 16'd0, 32'd2);
    put(ACT_POLL, 32'd0, 16'd0, 32'd2);
    // restart while busy, both buffers in flight, error bits in the final poll
    put(ACT_START, 32'd0, 16'hFFFF, ALL_ONES);
    put(ACT_START, $urandom(), 16'd2, 32'd0);
    put(ACT_POLL, 32'd0, 16'd0, 32'd0);
    put(ACT_POLL, 32'd0, 16'd0, 32'd1);
    put(ACT_REQUEST, 32'd0, 16'd0, 32'd0);
    put(ACT_REQUEST, 32'd0, 16'd0, 32'd0);
    put(ACT_SUBMIT, 32'd0, 16'd0, 32'd0);
    put(ACT_SUBMIT, 32'd0, 16'd0, 32'd0);
    put(ACT_POLL, 32'd0, 16'd0, 32'd16);
    put(ACT_POLL, 32'd0, 16'd0, 32'd16);
    put(ACT_POLL, 32'd0, 16'd0, 32'hFFFF_8000);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config({20'($urandom()), 12'd2048}, 32'd0, 32'h8000_0000, 32'd1,
                      32'h0000_8000, 32'd0);
        1: set_config(32'd1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        2: set_config($urandom_range(1, 2048), $urandom() & 32'hFFF0_0000,
                      32'd1 << $urandom_range(0, 19), 32'd1 << $urandom_range(0, 19),
                      32'd1 << $urandom_range(0, 19), $urandom());
        3: set_config(32'd512, 32'hFFFF_8000, 32'd1, 32'd2, 32'd16, 32'd423231522);
        default: set_config({20'($urandom()), 12'($urandom_range(1, 2048))}, 32'hFFFF_8000,
                            32'd0, 32'd1 << $urandom_range(0, 14),
                            32'd1 << $urandom_range(0, 14), $urandom());
      endcase
      if (phase == 2) hold_out = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_write_job();
    end

    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
